@@ hdl/wrat_pkg.sv @@
// Package for the windowed request/ack tracker.
// Holds the item codes, the sequencer states, field widths and shared helpers.
// No dependencies; used by wrat_ram and windowed_request_ack_tracker.
`default_nettype none

package wrat_pkg;

    // Default sizing of the tracker
    localparam int MAX_ENTRIES_DEF = 256;
    localparam int MAX_WINDOW_DEF  = 16;

    // Fixed field widths
    localparam int SEQ_W   = 32;
    localparam int ERR_W   = 13;
    localparam int IDX_W   = 8;
    localparam int KIND_W  = 2;
    localparam int RCNT_W  = 9;
    localparam int WSIZE_W = 5;
    localparam int FAIL_W  = 9;

    // Packed tdata widths, rounded up to whole bytes
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 56;

    // Sequence number of request zero
    localparam logic [SEQ_W-1:0] SEQ_ORIGIN = 32'h0001_0000;

    // Error code written on timeout
    localparam logic signed [ERR_W-1:0] ERR_TIMEDOUT = -13'sd110;

    // Input item kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_START   = 2'd0,
        KIND_ACK     = 2'd1,
        KIND_TIMEOUT = 2'd2,
        KIND_READ    = 2'd3
    } in_kind_t;

    // Result item kinds
    typedef enum logic [KIND_W-1:0] {
        OUT_ISSUE   = 2'd0,
        OUT_FINISH  = 2'd1,
        OUT_READOUT = 2'd2
    } out_kind_t;

    // Configuration register indexes
    typedef enum logic {
        REG_REQUEST_COUNT = 1'b0,
        REG_WINDOW_SIZE   = 1'b1
    } cfg_index_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADVANCE,
        ST_ACK_CHK,
        ST_ACK_UPD,
        ST_TO_RD,
        ST_TO_UPD,
        ST_RD_REQ,
        ST_RD_OUT
    } state_t;

    // Address width of a memory of the given depth
    function automatic int addr_w(input int depth);
        int w;
        w = (depth > 1) ? $clog2(depth) : 1;
        return w;
    endfunction

endpackage

`default_nettype wire

@@ hdl/wrat_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on wrat_pkg for the address width helper.
`default_nettype none

module wrat_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 256
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [wrat_pkg::addr_w(DEPTH)-1:0]    wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [wrat_pkg::addr_w(DEPTH)-1:0]    rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);
    import wrat_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, holds data while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/windowed_request_ack_tracker.sv @@
// Top level of the windowed request/ack tracker: sequencer, counters, result register.
// Depends on wrat_pkg and wrat_ram (entry table holding pending flag and error code).
`default_nettype none

// Takes one item at a time; s_axis_tready is high only while the sequencer idles.
// A start item issues requests up to the window, or reports the finish result of an
// empty batch. An ack of an issued, still pending entry reads the entry, writes it back
// and then issues the requests and finish result it frees, if any; a stray ack is
// dropped after the range check, an ack of an answered entry after the table read, and
// an ack or a timeout with no active batch is ignored in idle. A timeout reads each
// issued entry of the batch, writes back the still pending ones, then issues the
// results it causes. A read item reads its entry and reports it. The entry table has a
// single read port with registered data: each entry visit is one read, then a write-back
// where the entry changes. Entries never issued in the current batch read as pending
// whatever the table holds, so a start needs no clearing pass. Results wait in one output
// register; a stalled m_axis side holds the sequencer in place.
module windowed_request_ack_tracker #(
    parameter int MAX_ENTRIES = wrat_pkg::MAX_ENTRIES_DEF,
    parameter int MAX_WINDOW  = wrat_pkg::MAX_WINDOW_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write port
    input  logic                                cfg_we,
    input  logic                                cfg_addr,
    input  logic [wrat_pkg::RCNT_W-1:0]         cfg_wdata,
    // Input items
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: ack_seq[31:0], ack_error[44:32], entry_index[52:45], zeros above
    input  logic [wrat_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // tuser: kind[1:0]
    input  logic [wrat_pkg::KIND_W-1:0]         s_axis_tuser,
    // Result items
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: seq_number[31:0], entry_pending[32], entry_error[45:33],
    //        fail_count[54:46], zero at [55]
    output logic [wrat_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // tuser: out_kind[1:0]
    output logic [wrat_pkg::KIND_W-1:0]         m_axis_tuser,
    output logic                                m_axis_tlast
);
    import wrat_pkg::*;

    localparam int AW     = addr_w(MAX_ENTRIES);
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
    localparam int WORD_W = ERR_W + 1;

    // Configuration registers
    logic [RCNT_W-1:0]  cfg_count_reg;
    logic [WSIZE_W-1:0] cfg_window_reg;

    // Batch state
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   batch_n_reg, batch_n_next;
    logic [WIN_W-1:0]   win_reg, win_next;
    logic [CNT_W-1:0]   nti_reg, nti_next;
    logic [CNT_W-1:0]   done_reg, done_next;
    logic [WIN_W-1:0]   outst_reg, outst_next;
    logic [CNT_W-1:0]   fail_reg, fail_next;
    logic               active_reg, active_next;
    logic [CNT_W-1:0]   ptr_reg, ptr_next;

    // Latched input fields
    logic [SEQ_W-1:0]         seq_reg, seq_next;
    logic signed [ERR_W-1:0]  err_reg, err_next;
    logic [IDX_W-1:0]         index_reg, index_next;

    // Result register
    logic               out_valid_reg, out_valid_next;
    out_kind_t          out_kind_reg, out_kind_next;
    logic [SEQ_W-1:0]   out_seq_reg, out_seq_next;
    logic               out_pend_reg, out_pend_next;
    logic [ERR_W-1:0]   out_err_reg, out_err_next;
    logic [FAIL_W-1:0]  out_fail_reg, out_fail_next;
    logic               out_last_reg, out_last_next;

    // Entry table ports: word = {pending, error}
    logic               ram_wr_en;
    logic [AW-1:0]      ram_wr_addr;
    logic [WORD_W-1:0]  ram_wr_data;
    logic               ram_rd_en;
    logic [AW-1:0]      ram_rd_addr;
    logic [WORD_W-1:0]  ram_rd_data;

    // Derived conditions
    logic               can_emit;
    logic [SEQ_W-1:0]   ack_off;
    logic               ack_ok;
    logic               issue_ok;
    logic               issue_more;
    logic               rd_in_range;
    logic               rd_issued;
    logic               rd_pend;

    wrat_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_count_reg  <= '0;
            cfg_window_reg <= WSIZE_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_REQUEST_COUNT: cfg_count_reg  <= cfg_wdata;
                REG_WINDOW_SIZE:   cfg_window_reg <= cfg_wdata[WSIZE_W-1:0];
                default:           ;
            endcase
        end
    end

    // Handshake and ports
    assign can_emit      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {1'b0, out_fail_reg, out_err_reg, out_pend_reg, out_seq_reg};

    // Ack range check against issued requests
    assign ack_off = seq_reg - SEQ_ORIGIN;
    assign ack_ok  = (seq_reg >= SEQ_ORIGIN) && (ack_off < SEQ_W'(nti_reg));

    // Window room and remaining requests
    assign issue_ok   = (outst_reg < win_reg) && (nti_reg < batch_n_reg);
    assign issue_more = ((outst_reg + WIN_W'(1)) < win_reg)
                        && ((nti_reg + CNT_W'(1)) < batch_n_reg);

    // Readout classification
    assign rd_in_range = (32'(index_reg) < 32'(MAX_ENTRIES));
    assign rd_issued   = (32'(index_reg) < 32'(nti_reg));
    assign rd_pend     = ram_rd_data[ERR_W];

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        batch_n_next   = batch_n_reg;
        win_next       = win_reg;
        nti_next       = nti_reg;
        done_next      = done_reg;
        outst_next     = outst_reg;
        fail_next      = fail_reg;
        active_next    = active_reg;
        ptr_next       = ptr_reg;
        seq_next       = seq_reg;
        err_next       = err_reg;
        index_next     = index_reg;
        out_kind_next  = out_kind_reg;
        out_seq_next   = out_seq_reg;
        out_pend_next  = out_pend_reg;
        out_err_next   = out_err_reg;
        out_fail_next  = out_fail_reg;
        out_last_next  = out_last_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = '0;
        ram_wr_data    = '0;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = '0;

        // Drop the result once taken
        out_valid_next = out_valid_reg && !m_axis_tready;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    seq_next   = s_axis_tdata[31:0];
                    err_next   = s_axis_tdata[44:32];
                    index_next = s_axis_tdata[52:45];
                    case (s_axis_tuser)
                        KIND_START:
                        begin
                            // Latch the batch, clamp size and window
                            if (32'(cfg_count_reg) > 32'(MAX_ENTRIES))
                                batch_n_next = CNT_W'(MAX_ENTRIES);
                            else
                                batch_n_next = CNT_W'(cfg_count_reg);
                            if (cfg_window_reg == '0)
                                win_next = WIN_W'(1);
                            else if (32'(cfg_window_reg) > 32'(MAX_WINDOW))
                                win_next = WIN_W'(MAX_WINDOW);
                            else
                                win_next = WIN_W'(cfg_window_reg);
                            nti_next    = '0;
                            done_next   = '0;
                            outst_next  = '0;
                            fail_next   = '0;
                            active_next = 1'b1;
                            state_next  = ST_ADVANCE;
                        end
                        KIND_ACK:
                        begin
                            if (active_reg)
                                state_next = ST_ACK_CHK;
                        end
                        KIND_TIMEOUT:
                        begin
                            if (active_reg)
                            begin
                                ptr_next   = '0;
                                state_next = ST_TO_RD;
                            end
                        end
                        KIND_READ:
                        begin
                            state_next = ST_RD_REQ;
                        end
                        default: ;
                    endcase
                end
            end

            ST_ADVANCE:
            begin
                if (can_emit)
                begin
                    if (issue_ok)
                    begin
                        // Issue the next request and mark its entry pending
                        ram_wr_en      = 1'b1;
                        ram_wr_addr    = nti_reg[AW-1:0];
                        ram_wr_data    = {1'b1, {ERR_W{1'b0}}};
                        out_valid_next = 1'b1;
                        out_kind_next  = OUT_ISSUE;
                        out_seq_next   = SEQ_ORIGIN + SEQ_W'(nti_reg);
                        out_pend_next  = 1'b0;
                        out_err_next   = '0;
                        out_fail_next  = '0;
                        out_last_next  = !issue_more;
                        nti_next       = nti_reg + CNT_W'(1);
                        outst_next     = outst_reg + WIN_W'(1);
                        if (!issue_more)
                            state_next = ST_IDLE;
                    end
                    else if (done_reg >= batch_n_reg)
                    begin
                        // Every request answered: report and end the batch
                        out_valid_next = 1'b1;
                        out_kind_next  = OUT_FINISH;
                        out_seq_next   = '0;
                        out_pend_next  = 1'b0;
                        out_err_next   = '0;
                        out_fail_next  = FAIL_W'(fail_reg);
                        out_last_next  = 1'b1;
                        active_next    = 1'b0;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_ACK_CHK:
            begin
                // Fetch the entry of an in-range ack, drop a stray one
                if (ack_ok)
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = ack_off[AW-1:0];
                    state_next  = ST_ACK_UPD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_ACK_UPD:
            begin
                if (rd_pend)
                begin
                    // Record the error and free one window slot
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = ack_off[AW-1:0];
                    ram_wr_data = {1'b0, err_reg};
                    if (err_reg != '0)
                        fail_next = fail_reg + CNT_W'(1);
                    done_next = done_reg + CNT_W'(1);
                    if (outst_reg != '0)
                        outst_next = outst_reg - WIN_W'(1);
                    state_next = ST_ADVANCE;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_TO_RD:
            begin
                // Walk the issued entries
                if (ptr_reg < nti_reg)
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = ptr_reg[AW-1:0];
                    state_next  = ST_TO_UPD;
                end
                else
                begin
                    done_next  = nti_reg;
                    outst_next = '0;
                    state_next = ST_ADVANCE;
                end
            end

            ST_TO_UPD:
            begin
                // Mark a still pending entry timed out
                if (rd_pend)
                begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = ptr_reg[AW-1:0];
                    ram_wr_data = {1'b0, ERR_TIMEDOUT};
                    fail_next   = fail_reg + CNT_W'(1);
                end
                ptr_next   = ptr_reg + CNT_W'(1);
                state_next = ST_TO_RD;
            end

            ST_RD_REQ:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = AW'(index_reg);
                state_next  = ST_RD_OUT;
            end

            ST_RD_OUT:
            begin
                // Entries not yet issued in this batch read as pending
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = OUT_READOUT;
                    out_seq_next   = '0;
                    out_pend_next  = rd_in_range && (!rd_issued || rd_pend);
                    if (rd_in_range && rd_issued && !rd_pend)
                        out_err_next = ram_rd_data[ERR_W-1:0];
                    else
                        out_err_next = '0;
                    out_fail_next  = '0;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            batch_n_reg   <= '0;
            win_reg       <= WIN_W'(1);
            nti_reg       <= '0;
            done_reg      <= '0;
            outst_reg     <= '0;
            fail_reg      <= '0;
            active_reg    <= 1'b0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            batch_n_reg   <= batch_n_next;
            win_reg       <= win_next;
            nti_reg       <= nti_next;
            done_reg      <= done_next;
            outst_reg     <= outst_next;
            fail_reg      <= fail_next;
            active_reg    <= active_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        seq_reg      <= seq_next;
        err_reg      <= err_next;
        index_reg    <= index_next;
        out_kind_reg <= out_kind_next;
        out_seq_reg  <= out_seq_next;
        out_pend_reg <= out_pend_next;
        out_err_reg  <= out_err_next;
        out_fail_reg <= out_fail_next;
        out_last_reg <= out_last_next;
    end

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for windowed_request_ack_tracker: directed batches, then random ones.
// Keeps its own tracker state to predict every result; uses wrat_pkg for codes and widths.
`timescale 1ns / 1ps

module testbench;

    import wrat_pkg::*;

    localparam int ENTRIES = MAX_ENTRIES_DEF;
    localparam int WINDOW  = MAX_WINDOW_DEF;

    typedef struct packed {
        out_kind_t          kind;
        logic [SEQ_W-1:0]   seq;
        logic               pend;
        logic [ERR_W-1:0]   err;
        logic [FAIL_W-1:0]  fails;
        logic               last;
    } result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    cfg_index_t             cfg_addr = REG_REQUEST_COUNT;
    logic [RCNT_W-1:0]      cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [KIND_W-1:0]      s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [KIND_W-1:0]      m_axis_tuser;
    logic                   m_axis_tlast;

    // Tracker state as the predictor sees it
    bit                     trk_pending [ENTRIES];
    logic [ERR_W-1:0]       trk_error [ENTRIES];
    int unsigned            trk_next;
    int unsigned            trk_answered;
    int unsigned            trk_in_flight;
    int unsigned            trk_failed;
    int unsigned            trk_size;
    int unsigned            trk_window;
    bit                     trk_active;
    logic [RCNT_W-1:0]      reg_count;
    logic [WSIZE_W-1:0]     reg_window;

    result_t                expected_results [$];
    result_t                new_results [$];
    int                     mismatches = 0;
    int                     applied_items = 0;
    bit                     steady = 1'b0;

    windowed_request_ack_tracker dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stall the result side at random, except in a steady stretch
    always @(posedge clk)
    begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= 21);
    end

    function automatic void add_result(out_kind_t k, logic [SEQ_W-1:0] s, logic p,
                                       logic [ERR_W-1:0] e, logic [FAIL_W-1:0] f);
        result_t r;
        r.kind  = k;
        r.seq   = s;
        r.pend  = p;
        r.err   = e;
        r.fails = f;
        r.last  = 1'b0;
        new_results.push_back(r);
    endfunction

    // Fill the window with new requests, then close the batch once all are answered
    function automatic void issue_and_close();
        while (trk_in_flight < trk_window && trk_next < trk_size)
        begin
            add_result(OUT_ISSUE, SEQ_ORIGIN + trk_next, 1'b0, '0, '0);
            trk_next++;
            trk_in_flight++;
        end
        if (trk_answered >= trk_size)
        begin
            add_result(OUT_FINISH, '0, 1'b0, '0, trk_failed[FAIL_W-1:0]);
            trk_active = 1'b0;
        end
    endfunction

    // Advance the tracker state by one item; queue its results; flag whether it took effect
    function automatic bit predict_item(in_kind_t k, logic [SEQ_W-1:0] seq,
                                        logic [ERR_W-1:0] err, logic [IDX_W-1:0] idx);
        bit          took;
        int unsigned slot;
        took = 1'b0;
        new_results = {};
        case (k)
            KIND_START:
            begin
                trk_size   = (reg_count > ENTRIES) ? ENTRIES : reg_count;
                trk_window = (reg_window == 0) ? 1 : reg_window;
                if (trk_window > WINDOW)
                    trk_window = WINDOW;
                foreach (trk_pending[i])
                    trk_pending[i] = 1'b1;
                trk_next      = 0;
                trk_answered  = 0;
                trk_in_flight = 0;
                trk_failed    = 0;
                trk_active    = 1'b1;
                took          = 1'b1;
                issue_and_close();
            end
            KIND_ACK:
            begin
                if (trk_active && seq >= SEQ_ORIGIN && (seq - SEQ_ORIGIN) < trk_next)
                begin
                    slot = seq - SEQ_ORIGIN;
                    if (slot < ENTRIES && trk_pending[slot])
                    begin
                        trk_pending[slot] = 1'b0;
                        trk_error[slot]   = err;
                        if (err != 0)
                            trk_failed++;
                        trk_answered++;
                        if (trk_in_flight > 0)
                            trk_in_flight--;
                        took = 1'b1;
                        issue_and_close();
                    end
                end
            end
            KIND_TIMEOUT:
            begin
                if (trk_active)
                begin
                    for (int i = 0; i < trk_next && i < ENTRIES; i++)
                    begin
                        if (trk_pending[i])
                        begin
                            trk_pending[i] = 1'b0;
                            trk_error[i]   = ERR_TIMEDOUT;
                            trk_failed++;
                        end
                    end
                    trk_answered  = trk_next;
                    trk_in_flight = 0;
                    took          = 1'b1;
                    issue_and_close();
                end
            end
            default:
            begin
                // Pending entries report no error code
                add_result(OUT_READOUT, '0, trk_pending[idx],
                           trk_pending[idx] ? '0 : trk_error[idx], '0);
                took = 1'b1;
            end
        endcase
        if (new_results.size() > 0)
            new_results[new_results.size() - 1].last = 1'b1;
        foreach (new_results[i])
            expected_results.push_back(new_results[i]);
        return took;
    endfunction

    function automatic void check_field(string name, logic [SEQ_W-1:0] want,
                                        logic [SEQ_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual tuser %h tdata %h",
                         $time, m_axis_tuser, m_axis_tdata);
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("out_kind", 32'(want.kind), 32'(m_axis_tuser));
                check_field("seq_number", want.seq, m_axis_tdata[31:0]);
                check_field("entry_pending", 32'(want.pend), 32'(m_axis_tdata[32]));
                check_field("entry_error", 32'(want.err), 32'(m_axis_tdata[45:33]));
                check_field("fail_count", 32'(want.fails), 32'(m_axis_tdata[54:46]));
                check_field("last", 32'(want.last), 32'(m_axis_tlast));
            end
        end
    end

    function automatic logic [ERR_W-1:0] rand_err();
        logic [ERR_W-1:0] e;
        e = '0;
        if ($urandom_range(0, 1))
            e = ERR_W'(0 - $urandom_range(1, 4095));
        return e;
    endfunction

    // Present one item, hold it until accepted, then predict its results
    task automatic send_item(in_kind_t k, logic [SEQ_W-1:0] seq, logic [ERR_W-1:0] err,
                             logic [IDX_W-1:0] idx);
        while (!steady && $urandom_range(0, 99) < 21)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, idx, err, seq};
        s_axis_tuser  <= k;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (predict_item(k, seq, err, idx))
            applied_items++;
    endtask

    // Drop valid, drain all expected results, then let ignored items settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_config(logic [RCNT_W-1:0] count, logic [RCNT_W-1:0] win_word);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_REQUEST_COUNT;
        cfg_wdata <= count;
        @(posedge clk);
        cfg_addr  <= REG_WINDOW_SIZE;
        cfg_wdata <= win_word;
        @(posedge clk);
        cfg_we    <= 1'b0;
        reg_count  = count;
        reg_window = win_word[WSIZE_W-1:0];
    endtask

    // Reads before any batch, and idle acks and timeouts that must be ignored
    task automatic test_reset_readout();
        send_item(KIND_READ, '0, '0, 8'd0);
        send_item(KIND_READ, 32'hFFFF_FFFF, 13'h1FFF, 8'd255);
        send_item(KIND_ACK, SEQ_ORIGIN, '0, 8'd0);
        send_item(KIND_TIMEOUT, '0, '0, 8'd0);
    endtask

    // A start with no requests finishes at once
    task automatic test_empty_batch();
        wait_idle();
        set_config(9'd0, 9'd5);
        send_item(KIND_START, '0, '0, 8'd0);
        send_item(KIND_ACK, SEQ_ORIGIN, '0, 8'd0);
    endtask

    // Zero window, stray and duplicate acks, timeout, restart, ack without new issue
    task automatic test_windowed_batch();
        wait_idle();
        set_config(9'd4, 9'd0);
        send_item(KIND_START, '0, '0, 8'd0);
        send_item(KIND_ACK, SEQ_ORIGIN + 1, '0, 8'd0);
        send_item(KIND_ACK, SEQ_ORIGIN, -13'sd4095, 8'd0);
        send_item(KIND_ACK, SEQ_ORIGIN, '0, 8'd0);
        send_item(KIND_ACK, 32'hFFFF_FFFF, '0, 8'd0);
        send_item(KIND_ACK, 32'h0000_0000, '0, 8'd0);
        send_item(KIND_READ, '0, '0, 8'd0);
        send_item(KIND_READ, '0, '0, 8'd1);
        send_item(KIND_TIMEOUT, '0, '0, 8'd0);
        send_item(KIND_READ, '0, '0, 8'd1);
        send_item(KIND_ACK, SEQ_ORIGIN + 2, '0, 8'd0);
        send_item(KIND_START, '0, '0, 8'd0);
        wait_idle();
        set_config(9'd3, 9'd2);
        send_item(KIND_START, '0, '0, 8'd0);
        send_item(KIND_ACK, SEQ_ORIGIN, '0, 8'd0);
        send_item(KIND_ACK, SEQ_ORIGIN + 1, 13'h1FFF, 8'd0);
        send_item(KIND_ACK, SEQ_ORIGIN + 2, '0, 8'd0);
        send_item(KIND_READ, '0, '0, 8'd255);
    endtask

    // Oversized registers saturate; sweep a full table with timeouts, no idling
    task automatic test_saturated_config();
        wait_idle();
        steady = 1'b1;
        set_config(9'h1FF, 9'h1FF);
        send_item(KIND_START, '0, '0, 8'd0);
        send_item(KIND_ACK, SEQ_ORIGIN + 15, 13'h1FFF, 8'd0);
        send_item(KIND_READ, '0, '0, 8'd255);
        while (trk_active)
            send_item(KIND_TIMEOUT, $urandom(), rand_err(), IDX_W'($urandom_range(0, 255)));
        send_item(KIND_READ, '0, '0, 8'd15);
        steady = 1'b0;
    endtask

    // Random batches: mostly acks of open requests, with stray items and noise
    task automatic test_random_batches();
        int unsigned      goal;
        int               batch;
        int               steps;
        int               r;
        int unsigned      count;
        logic [RCNT_W-1:0] win_word;
        int unsigned      open_slots [$];
        int unsigned      closed_slots [$];
        logic [SEQ_W-1:0] seq;
        goal  = applied_items + 100;
        batch = 0;
        while (applied_items < goal)
        begin
            batch++;
            wait_idle();
            steady = (batch >= 3 && batch <= 5);
            r = $urandom_range(0, 99);
            if (r < 5)
                count = 0;
            else if (r < 90)
                count = $urandom_range(1, 24);
            else
                count = $urandom_range(25, 511);
            win_word = RCNT_W'($urandom_range(0, 511));
            if (count > 24)
                win_word[WSIZE_W-1:0] = WSIZE_W'($urandom_range(8, 31));
            set_config(RCNT_W'(count), win_word);
            send_item(KIND_START, $urandom(), rand_err(), IDX_W'($urandom_range(0, 255)));
            steps = 0;
            while (trk_active && steps < 40)
            begin
                steps++;
                open_slots = {};
                closed_slots = {};
                for (int i = 0; i < trk_next && i < ENTRIES; i++)
                begin
                    if (trk_pending[i])
                        open_slots.push_back(i);
                    else
                        closed_slots.push_back(i);
                end
                r = $urandom_range(0, 99);
                if (r < 65 && open_slots.size() > 0)
                    send_item(KIND_ACK,
                              SEQ_ORIGIN + open_slots[$urandom_range(0, open_slots.size() - 1)],
                              rand_err(), IDX_W'($urandom_range(0, 255)));
                else if (r < 75)
                    send_item(KIND_READ, $urandom(), rand_err(),
                              IDX_W'($urandom_range(0, 255)));
                else if (r < 83)
                begin
                    case ($urandom_range(0, 3))
                        0: seq = $urandom();
                        1: seq = SEQ_ORIGIN + trk_next + $urandom_range(0, 300);
                        2: seq = (closed_slots.size() > 0) ?
                                 SEQ_ORIGIN + closed_slots[$urandom_range(0,
                                                                closed_slots.size() - 1)] :
                                 SEQ_ORIGIN - 1;
                        default: seq = $urandom_range(0, SEQ_ORIGIN - 1);
                    endcase
                    send_item(KIND_ACK, seq, rand_err(), IDX_W'($urandom_range(0, 255)));
                end
                else if (r < 90 || open_slots.size() == 0)
                    send_item(KIND_TIMEOUT, $urandom(), rand_err(),
                              IDX_W'($urandom_range(0, 255)));
                else if (r < 92)
                    send_item(KIND_START, $urandom(), rand_err(),
                              IDX_W'($urandom_range(0, 255)));
                else
                    send_item(in_kind_t'($urandom_range(0, 3)), $urandom(), rand_err(),
                              IDX_W'($urandom_range(0, 255)));
            end
            // Close long batches with timeout sweeps, or leave them for a restart
            if (trk_active && $urandom_range(0, 1))
            begin
                while (trk_active)
                    send_item(KIND_TIMEOUT, $urandom(), rand_err(),
                              IDX_W'($urandom_range(0, 255)));
            end
        end
        steady = 1'b0;
    endtask

    initial
    begin
        foreach (trk_pending[i])
        begin
            trk_pending[i] = 1'b1;
            trk_error[i]   = '0;
        end
        trk_next      = 0;
        trk_answered  = 0;
        trk_in_flight = 0;
        trk_failed    = 0;
        trk_size      = 0;
        trk_window    = 1;
        trk_active    = 1'b0;
        reg_count     = '0;
        reg_window    = 5'd1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_readout();
        test_empty_batch();
        test_windowed_batch();
        test_saturated_config();
        test_random_batches();
        wait_idle();
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Hard stop if the run hangs
    initial
    begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ windowed_request_ack_tracker.f @@
hdl/wrat_pkg.sv
hdl/wrat_ram.sv
hdl/windowed_request_ack_tracker.sv
tb/testbench.sv
